### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; the SYNTH define selects empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("never violated");
`else
`define ASSERT_IMPL(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

### rtl/core/fmsd_pkg.sv
// Package for the feature mean / sigma unit: types and constants.
// No dependencies.
package fmsd_pkg;
  localparam int unsigned Features   = 8;
  localparam int unsigned Slots      = 8;
  localparam int unsigned Active     = (Features < Slots) ? Features : Slots;
  localparam int unsigned MaxVectors = 128;
  localparam int unsigned SumW       = 32;
  localparam int unsigned SqW        = 54;
  localparam int unsigned CntW       = 11;
  localparam logic [22:0] SigmaOne   = 23'd4096;
  localparam logic [22:0] SigmaMax   = 23'h7FFFFF;
  localparam logic [48:0] VarFloor   = 49'd16;

  typedef enum logic {
    CMD_ACCUM  = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACC,
    PH_DIVS,
    PH_DIVQ,
    PH_SQRT,
    PH_EMIT
  } phase_e;

  typedef struct packed {
    logic               command;
    logic [2:0]         feature_index;
    logic signed [23:0] value;
    logic               vector_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         feature_out;
    logic signed [23:0] mean;
    logic [22:0]        sigma;
    logic               updated;
    logic               last;
  } out_item_t;

  // Cell contents that travel around the ring.
  typedef struct packed {
    logic [SumW-1:0]    sum;
    logic [SqW-1:0]     sq;
    logic signed [23:0] mean;
    logic [22:0]        sigma;
  } cell_t;

  // Control from the sequencer to every cell.
  typedef struct packed {
    logic              acc;
    logic [2:0]        idx;
    logic signed [47:0] sq_val;
    logic signed [23:0] val;
    logic              shift;
  } cell_ctl_t;
endpackage

### rtl/core/fmsd_cell.sv
// One feature cell of the ring: holds sum, sum of squares and last stats.
// Depends on fmsd_pkg.
module fmsd_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         my_idx_i,
  input  fmsd_pkg::cell_ctl_t ctl_i,
  input  fmsd_pkg::cell_t    prev_i,
  output fmsd_pkg::cell_t    cell_o
);
  fmsd_pkg::cell_t cell_q, cell_d;

  always_comb begin
    cell_d = cell_q;
    if (ctl_i.shift) begin
      cell_d = prev_i;
    end else if (ctl_i.acc && (ctl_i.idx == my_idx_i)) begin
      cell_d.sum = cell_q.sum + {{(fmsd_pkg::SumW-24){ctl_i.val[23]}}, ctl_i.val};
      cell_d.sq  = cell_q.sq + {6'd0, ctl_i.sq_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;
endmodule

### rtl/core/fmsd_divsqrt.sv
// Shared bit-serial unit: restoring divide of 56-bit value by count,
// then 48-bit integer square root. No dependencies.
module fmsd_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        div_start_i,
  input  logic [55:0] dividend_i,
  input  logic [10:0] divisor_i,
  output logic        div_done_o,
  output logic [55:0] quot_o,
  input  logic        sqrt_start_i,
  input  logic [47:0] rad_i,
  output logic        sqrt_done_o,
  output logic [23:0] root_o
);
  logic [55:0] q_q, q_d;
  logic [11:0] r_q, r_d;
  logic [5:0]  dn_q, dn_d;
  logic        dbusy_q, dbusy_d;
  logic [47:0] x_q, x_d;
  logic [24:0] rt_q, rt_d;
  logic [4:0]  sn_q, sn_d;
  logic        sbusy_q, sbusy_d;
  logic [11:0] rs;
  logic [55:0] q_step;
  logic [11:0] r_step;
  logic [49:0] trial;
  logic [49:0] rem;

  always_comb begin
    q_d = q_q; r_d = r_q; dn_d = dn_q; dbusy_d = dbusy_q;
    div_done_o = 1'b0;
    rs = {r_q[10:0], q_q[55]};
    if (rs >= {1'b0, divisor_i}) begin
      r_step = rs - {1'b0, divisor_i};
      q_step = {q_q[54:0], 1'b1};
    end else begin
      r_step = rs;
      q_step = {q_q[54:0], 1'b0};
    end
    if (dbusy_q) begin
      q_d = q_step;
      r_d = r_step;
      if (dn_q == 6'd0) begin
        dbusy_d = 1'b0;
        div_done_o = 1'b1;
      end else begin
        dn_d = dn_q - 6'd1;
      end
    end
    // a new divide may load in the cycle the previous one finishes
    if (div_start_i) begin
      q_d = dividend_i; r_d = '0; dn_d = 6'd55; dbusy_d = 1'b1;
    end
  end
  assign quot_o = q_step;

  // Digit-by-digit root: rem holds partial remainder, rt the root so far.
  always_comb begin
    x_d = x_q; rt_d = rt_q; sn_d = sn_q; sbusy_d = sbusy_q;
    sqrt_done_o = 1'b0;
    trial = '0;
    rem = '0;
    if (sqrt_start_i) begin
      x_d = rad_i; rt_d = '0; sn_d = 5'd23; sbusy_d = 1'b1;
    end else if (sbusy_q) begin
      // x_q keeps remainder in low bits via shifted scheme
      rem   = {2'b00, x_q};
      trial = ({25'd0, rt_q} << 2 | 50'd1) << (2 * sn_q);
      if (rem >= trial) begin
        x_d  = x_q - trial[47:0];
        rt_d = {rt_q[23:0], 1'b1};
      end else begin
        rt_d = {rt_q[23:0], 1'b0};
      end
      if (sn_q == 5'd0) begin
        sbusy_d = 1'b0;
        sqrt_done_o = 1'b1;
      end else begin
        sn_d = sn_q - 5'd1;
      end
    end
  end
  assign root_o = rt_d[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      sbusy_q <= 1'b0;
      dn_q    <= '0;
      sn_q    <= '0;
    end else begin
      dbusy_q <= dbusy_d;
      sbusy_q <= sbusy_d;
      dn_q    <= dn_d;
      sn_q    <= sn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    r_q  <= r_d;
    x_q  <= x_d;
    rt_q <= rt_d;
  end
endmodule

### rtl/core/feature_mean_stdev_unit.sv
// Top level of the feature mean / sigma unit.
// Depends on fmsd_pkg, fmsd_cell, fmsd_divsqrt and assert_macros.svh.
//
// Accumulate items: the square is registered at accept, then added into
// the addressed cell. A finish item rotates the ring of eight cells; the
// head cell is worked on by one shared bit-serial unit: sum divide,
// square-sum divide, a check of the variance, then a root (the root is
// skipped when the variance is tiny or large enough to saturate sigma).
// With fewer than two vectors the divides and the root are skipped. Results
// leave on out_valid_o for one cycle each in feature order; the receiver
// cannot stall. busy is high until the last result has gone.
`include "assert_macros.svh"
module feature_mean_stdev_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  fmsd_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  output fmsd_pkg::out_item_t  out_o
);
  fmsd_pkg::phase_e ph_q, ph_d;
  logic [fmsd_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [2:0] fi_q, fi_d;
  logic       upd_q, upd_d;
  fmsd_pkg::in_item_t it_q;
  logic signed [47:0] sq_q;
  logic signed [23:0] mu_q, mu_d;
  logic [53:0] ex2_q, ex2_d;
  logic signed [23:0] mean_new;
  logic [22:0] sig_new;

  fmsd_pkg::cell_t   cells [fmsd_pkg::Slots];
  fmsd_pkg::cell_t   ring_in [fmsd_pkg::Slots];
  fmsd_pkg::cell_ctl_t ctl;
  fmsd_pkg::cell_t   head_new;

  logic        div_start, div_done, sqrt_start, sqrt_done;
  logic [55:0] dividend, quot;
  logic [47:0] rad;
  logic [23:0] root;

  logic               sneg;
  logic [31:0]        sabs;
  logic [10:0]        halfn;
  logic signed [54:0] var_v;
  logic signed [47:0] mu_sq;
  logic               var_big;
  logic               need_root;

  genvar g;
  generate
    for (g = 0; g < fmsd_pkg::Slots; g++) begin : g_cell
      assign ring_in[g] = (g == fmsd_pkg::Slots - 1) ? head_new
                          : cells[(g + 1) % fmsd_pkg::Slots];
      fmsd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .my_idx_i(3'(g)),
        .ctl_i   (ctl),
        .prev_i  (ring_in[g]),
        .cell_o  (cells[g])
      );
    end
  endgenerate

  fmsd_divsqrt u_ds (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .div_start_i (div_start),
    .dividend_i  (dividend),
    .divisor_i   (cnt_q),
    .div_done_o  (div_done),
    .quot_o      (quot),
    .sqrt_start_i(sqrt_start),
    .rad_i       (rad),
    .sqrt_done_o (sqrt_done),
    .root_o      (root)
  );

  assign sneg  = cells[0].sum[31];
  assign sabs  = sneg ? (32'd0 - cells[0].sum) : cells[0].sum;
  assign halfn = {1'b0, cnt_q[10:1]};
  assign mu_sq = mu_q * mu_q;
  assign var_v = $signed({1'b0, ex2_q}) - {{7{mu_sq[47]}}, mu_sq};
  // at or above 2^46 the root exceeds the largest sigma
  assign var_big   = !var_v[54] && (var_v[53:46] != '0);
  assign need_root = upd_q && (var_v > $signed(fmsd_pkg::VarFloor)) && !var_big;

  always_comb begin
    ph_d = ph_q; cnt_d = cnt_q; fi_d = fi_q; upd_d = upd_q;
    mu_d = mu_q; ex2_d = ex2_q;
    ctl = '0;
    ctl.idx = it_q.feature_index;
    ctl.val = it_q.value;
    ctl.sq_val = sq_q;
    div_start = 1'b0; sqrt_start = 1'b0;
    dividend = '0; rad = '0;
    head_new = cells[0];
    mean_new = cells[0].mean;
    sig_new  = cells[0].sigma;
    out_valid_o = 1'b0;
    out_o = '0;
    busy = (ph_q != fmsd_pkg::PH_IDLE);
    case (ph_q)
      fmsd_pkg::PH_IDLE: begin
        if (start) begin
          if (in_i.command == fmsd_pkg::CMD_ACCUM) begin
            if (cnt_q < 11'(fmsd_pkg::MaxVectors)) ph_d = fmsd_pkg::PH_ACC;
          end else begin
            fi_d = '0;
            upd_d = (cnt_q >= 11'd2);
            if (cnt_q >= 11'd2) begin
              ph_d = fmsd_pkg::PH_DIVS;
              div_start = 1'b1;
              dividend = {24'd0, sabs} + {45'd0, halfn};
            end else begin
              ph_d = fmsd_pkg::PH_EMIT;
            end
          end
        end
      end
      fmsd_pkg::PH_ACC: begin
        ctl.acc = (32'(it_q.feature_index) < fmsd_pkg::Active);
        if (it_q.vector_end) cnt_d = cnt_q + 11'd1;
        ph_d = fmsd_pkg::PH_IDLE;
      end
      fmsd_pkg::PH_DIVS: begin
        if (div_done) begin
          if (sneg) begin
            mu_d = (quot > 56'd8388608) ? -24'sd8388608 : 24'(56'd0 - quot);
          end else begin
            mu_d = (quot > 56'd8388607) ? 24'sd8388607 : quot[23:0];
          end
          div_start = 1'b1;
          dividend = {2'b00, cells[0].sq} + {45'd0, halfn};
          ph_d = fmsd_pkg::PH_DIVQ;
        end
      end
      fmsd_pkg::PH_DIVQ: begin
        if (div_done) begin
          ex2_d = quot[53:0];
          ph_d = fmsd_pkg::PH_SQRT;
        end
      end
      fmsd_pkg::PH_SQRT: begin
        if (need_root) begin
          rad = var_v[47:0];
          sqrt_start = 1'b1;
        end
        ph_d = fmsd_pkg::PH_EMIT;
      end
      fmsd_pkg::PH_EMIT: begin
        if (!need_root || sqrt_done) begin
          if (upd_q) begin
            mean_new = mu_q;
            if (var_v <= $signed(fmsd_pkg::VarFloor)) begin
              sig_new = fmsd_pkg::SigmaOne;
            end else if (var_big) begin
              sig_new = fmsd_pkg::SigmaMax;
            end else begin
              sig_new = (root > 24'(fmsd_pkg::SigmaMax)) ? fmsd_pkg::SigmaMax
                                                         : root[22:0];
            end
          end
          out_valid_o = (32'(fi_q) < fmsd_pkg::Active);
          out_o.feature_out = fi_q;
          out_o.mean = mean_new;
          out_o.sigma = sig_new;
          out_o.updated = upd_q;
          out_o.last = (32'(fi_q) == fmsd_pkg::Active - 1);
          head_new.sum = '0;
          head_new.sq = '0;
          head_new.mean = mean_new;
          head_new.sigma = sig_new;
          ctl.shift = 1'b1;
          fi_d = fi_q + 3'd1;
          if (fi_q == 3'(fmsd_pkg::Slots - 1)) begin
            ph_d = fmsd_pkg::PH_IDLE;
            cnt_d = '0;
          end else if (upd_q) begin
            ph_d = fmsd_pkg::PH_DIVS;
            div_start = 1'b1;
            dividend = {24'd0, (cells[1].sum[31] ? (32'd0 - cells[1].sum)
                                                   : cells[1].sum)}
                       + {45'd0, halfn};
          end
        end
      end
      default: ph_d = fmsd_pkg::PH_IDLE;
    endcase
  end

  // sign of next head must be known in PH_DIVS; it is cells[0] after shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= fmsd_pkg::PH_IDLE;
      cnt_q <= '0;
      fi_q  <= '0;
      upd_q <= 1'b0;
    end else begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      fi_q  <= fi_d;
      upd_q <= upd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      it_q <= in_i;
      sq_q <= in_i.value * in_i.value;
    end
    mu_q  <= mu_d;
    ex2_q <= ex2_d;
  end

  `ASSERT_NEVER(a_no_out_idle, clk_i, rst_ni, out_valid_o && (ph_q == fmsd_pkg::PH_IDLE))
  `ASSERT_IMPL(a_busy_after_finish, clk_i, rst_ni,
    (start && !busy && in_i.command == fmsd_pkg::CMD_FINISH) |=> busy)
  `ASSERT_IMPL(a_cnt_clear, clk_i, rst_ni,
    (out_valid_o && out_o.last) |=> (cnt_q == '0))
endmodule

### sim/feature_mean_stdev_unit_test.sv
// Testbench for feature_mean_stdev_unit: random and directed accumulate/finish items.
// Depends on fmsd_pkg and the RTL; predicts results with a local model and a result queue.
`timescale 1ns / 100ps
module feature_mean_stdev_unit_test;

  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  fmsd_pkg::in_item_t in_i = '0;
  logic out_valid_o;
  fmsd_pkg::out_item_t out_o;

  feature_mean_stdev_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_o(out_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [31:0] acc_sum [8];
  logic [53:0] acc_sq [8];
  logic [10:0] vec_count;
  logic signed [23:0] last_mean [8];
  logic [22:0] last_sigma [8];

  fmsd_pkg::in_item_t pending_items [$];
  fmsd_pkg::out_item_t expected_stats [$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit drain_hold = 1'b0;   // pause sender until all results are back
  int watch = 0;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_stats(fmsd_pkg::in_item_t it);
    longint n, s, q, mu, ex2, var_q;
    logic [63:0] a, r;
    fmsd_pkg::out_item_t o;
    if (it.command == fmsd_pkg::CMD_ACCUM) begin
      if (vec_count >= fmsd_pkg::MaxVectors) return;
      if (it.feature_index < fmsd_pkg::Active) begin
        acc_sum[it.feature_index] += 32'(longint'(it.value));
        acc_sq[it.feature_index] += 54'(longint'(it.value) * longint'(it.value));
      end
      if (it.vector_end) vec_count++;
      return;
    end
    for (int f = 0; f < fmsd_pkg::Active; f++) begin
      o = '0;
      if (vec_count >= 2) begin
        n = vec_count;
        s = longint'($signed(acc_sum[f]));
        a = (s < 0) ? -s : s;
        q = (a + n / 2) / n;
        mu = (s < 0) ? -q : q;
        if (mu > 8388607) mu = 8388607;
        if (mu < -8388608) mu = -8388608;
        ex2 = (64'(acc_sq[f]) + n / 2) / n;
        var_q = ex2 - mu * mu;
        last_mean[f] = 24'(mu);
        if (var_q > longint'(fmsd_pkg::VarFloor)) begin
          r = int_sqrt(var_q);
          last_sigma[f] = (r > 64'(fmsd_pkg::SigmaMax)) ? fmsd_pkg::SigmaMax : 23'(r);
        end else begin
          last_sigma[f] = fmsd_pkg::SigmaOne;
        end
        o.updated = 1'b1;
      end
      o.feature_out = 3'(f);
      o.mean = last_mean[f];
      o.sigma = last_sigma[f];
      o.last = (f == fmsd_pkg::Active - 1);
      expected_stats.push_back(o);
    end
    foreach (acc_sum[i]) begin
      acc_sum[i] = '0;
      acc_sq[i] = '0;
    end
    vec_count = '0;
  endtask

  // driver: bursts with gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_stats(in_i);
      end
      if (start && busy) begin
        // hold current item
      end else if (drain_hold && (expected_stats.size() != 0 || busy)) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_i <= pending_items.pop_front();
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_o);
        errors++;
      end else if (out_o !== expected_stats[0]) begin
        $display("%0t: mismatch expected %p actual %p", $time, expected_stats[0], out_o);
        errors++;
        void'(expected_stats.pop_front());
      end else begin
        void'(expected_stats.pop_front());
      end
    end
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || out_valid_o) begin
        watch <= 0;
      end else begin
        watch <= watch + 1;
      end
      if (watch >= WatchLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic fmsd_pkg::in_item_t mk(bit cmd, int idx, int val, bit vend);
    fmsd_pkg::in_item_t it;
    it.command = cmd ? fmsd_pkg::CMD_FINISH : fmsd_pkg::CMD_ACCUM;
    it.feature_index = 3'(idx);
    it.value = 24'(val);
    it.vector_end = vend;
    return it;
  endfunction

  // one vector of random content; most values within +/-span, some extreme
  task automatic add_vector(int span);
    int v;
    for (int f = 0; f < 8; f++) begin
      case ($urandom_range(0, 9))
        0: v = 8388607;
        1: v = -8388608;
        2: v = $urandom;
        default: v = $urandom_range(0, 2 * span) - span;
      endcase
      pending_items.push_back(mk(0, f, v, f == 7));
    end
  endtask

  initial begin
    int span;
    foreach (acc_sum[i]) begin
      acc_sum[i] = '0;
      acc_sq[i] = '0;
      last_mean[i] = '0;
      last_sigma[i] = '0;
    end
    vec_count = '0;
    // directed: finish with nothing loaded, one vector only, extremes, constant data
    pending_items.push_back(mk(1, 7, -1, 1));
    pending_items.push_back(mk(0, 0, 8388607, 0));
    pending_items.push_back(mk(0, 7, -8388608, 1));
    pending_items.push_back(mk(1, 0, 0, 0));
    for (int k = 0; k < 3; k++)
      for (int f = 0; f < 8; f++) pending_items.push_back(mk(0, f, 4096 * f, f == 7));
    pending_items.push_back(mk(0, 2, 5, 0));           // unfinished vector
    pending_items.push_back(mk(1, 0, 0, 0));
    for (int k = 0; k < 2; k++) begin
      pending_items.push_back(mk(0, 0, (k ? 8388607 : -8388608), 0));
      pending_items.push_back(mk(0, 5, (k ? -8388608 : 8388607), 1));
    end
    pending_items.push_back(mk(1, 3, 8388607, 1));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // random: sets of vectors then a finish
    for (int set = 0; set < 8; set++) begin
      span = (set % 3 == 0) ? 8388608 : $urandom_range(1, 20000);
      repeat ($urandom_range(1, 5)) add_vector(span);
      repeat ($urandom_range(0, 3))
        pending_items.push_back(mk(0, $urandom_range(0, 7), $urandom, $urandom_range(0, 1)));
      pending_items.push_back(mk(1, $urandom_range(0, 7), $urandom, $urandom_range(0, 1)));
    end
    // past the vector limit once
    for (int k = 0; k < 132; k++)
      pending_items.push_back(mk(0, 0, $urandom_range(0, 100), 1));
    pending_items.push_back(mk(0, 1, 8388607, 1));
    pending_items.push_back(mk(1, 0, 0, 0));
    wait (pending_items.size() == 0);
    drain_hold = 1'b1;
    @(posedge clk_i);
    wait (expected_stats.size() == 0 && !busy);
    drain_hold = 1'b0;
    for (int k = 0; k < 6; k++) begin
      repeat (2) add_vector(3000);
      pending_items.push_back(mk(1, 0, 0, 0));
    end
    wait (pending_items.size() == 0);
    @(posedge clk_i);
    while (start || busy || expected_stats.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_stats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
